// File: rtl/core/dcgi_pkg.sv
// Shared constants and types for the dual channel grid interpolator.
`timescale 1ns / 1ps
`default_nettype none
package dcgi_pkg;
    localparam int QueueDepth = 32;
    localparam int QAW = $clog2(QueueDepth);
    localparam int QCW = $clog2(QueueDepth + 1);
    localparam int TimelineLen = 4;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic CFG_STEP  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // Divider control between the sequencer and the divide unit.
    typedef struct packed {
        logic        start;
        logic [63:0] num_mag;
        logic [27:0] den;
    } div_req_t;
endpackage
`default_nettype wire

// File: rtl/core/dcgi_div.sv
// Radix-2 restoring divider: 64-bit magnitude by 28-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module dcgi_div
    import dcgi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    output logic             done,
    output logic [63:0]      quot
);
    logic [63:0] q_reg;
    logic [28:0] rem_reg;
    logic [27:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [28:0] shifted;
    logic [28:0] diff;

    assign shifted = {rem_reg[27:0], q_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= req.num_mag;
                den_reg  <= req.den;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (!diff[28])
                begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/dual_channel_grid_interpolator_unit.sv
// Top level of the dual channel grid interpolator.
// Input channel (valid/ready): op, channel, sample_value, timestamp_ms.
//   op 0 adds a reading (refused when same channel as the newest one),
//   op 1 reads one interpolated pair, op 2 clears the timeline, op 3 is dropped.
// Output channel (valid/ready): got_pair, value_first, value_second; one item per
//   op 1 only. Values are signed Q16.16, channel 0 always in value_first.
// Config port: cfg_we/cfg_index/cfg_data; index 0 step_ms, index 1 queue_limit.
// Timing: ops 0, 2, 3 complete in S_IDLE. A read with an empty queue and a fresh,
//   well-formed four-reading timeline first runs the point count division, then
//   generates up to queue_limit pairs (at most QueueDepth), each needing two divisions
//   on the shared serial divider plus a multiply and saturate. A read without
//   generation passes S_CHECK, S_POP, S_MEMRD and S_OUT, then registers its item.
//   The divider sets the rate.
// in_ready is high whenever the sequencer is idle. An item waiting in the output
//   register holds a later read at its last step, so a long output stall ends up
//   blocking the input at the next read.
// Reset clears the timeline count, fresh flag, queue pointers and restores
//   step_ms 50, queue_limit 30. Queue storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dual_channel_grid_interpolator_unit
    import dcgi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic               channel,
    input  wire logic signed [31:0] sample_value,
    input  wire logic [26:0]        timestamp_ms,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    got_pair,
    output logic signed [31:0]      value_first,
    output logic signed [31:0]      value_second,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [9:0]         cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SETUP, S_POINT, S_MUL, S_DIV, S_ACC, S_NEXT, S_POP, S_MEMRD,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [9:0]  step_reg;
    logic [5:0]  limit_reg;
    logic        nch_reg [TimelineLen];
    logic signed [31:0] nval_reg [TimelineLen];
    logic [26:0] ntim_reg [TimelineLen];
    logic [2:0]  ncnt_reg;
    logic        fresh_reg;
    logic [63:0] queue_mem [QueueDepth];
    logic [QAW-1:0] head_reg;
    logic [QCW-1:0] qcnt_reg;
    logic [63:0] rd_reg;

    logic [26:0] kidx_reg;    // current grid index k
    logic [26:0] kend_reg;    // n
    logic        lane_reg;    // 0: channel pair a, 1: pair b
    logic signed [32:0] diff_reg;
    logic signed [28:0] off_reg;
    logic signed [61:0] prod_reg;
    logic        neg_reg;
    logic signed [31:0] a_reg;
    div_req_t    dreq;
    logic        ddone;
    logic [63:0] dquot;

    dcgi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

    // Derived quantities from the timeline.
    logic [9:0]  step_eff;
    logic signed [27:0] d1, d2, gspan;
    logic [5:0]  limit_eff;
    logic [26:0] n_pts;
    logic [26:0] i_pt;
    logic signed [64:0] sum_full;
    logic signed [31:0] sat_val;
    logic        out_free;

    assign step_eff = (step_reg == 10'd0) ? 10'd1 : step_reg;
    assign d1 = $signed({1'b0, ntim_reg[2]}) - $signed({1'b0, ntim_reg[0]});
    assign d2 = $signed({1'b0, ntim_reg[3]}) - $signed({1'b0, ntim_reg[1]});
    assign gspan = $signed({1'b0, ntim_reg[2]}) - $signed({1'b0, ntim_reg[1]});
    assign limit_eff = (limit_reg > 6'(QueueDepth)) ? 6'(QueueDepth) : limit_reg;
    assign i_pt = 27'(ntim_reg[1] + 27'(kidx_reg * step_eff));

    // Count grid points: n = ceil(span/step); computed on the serial divider, started in S_SETUP and taken in S_NEXT.
    assign n_pts = kend_reg;

    assign sum_full = (lane_reg ? 65'(nval_reg[1]) : 65'(nval_reg[0]))
                    + (neg_reg ? -$signed({1'b0, dquot}) : $signed({1'b0, dquot}));
    always_comb
    begin
        if (sum_full > 65'sd2147483647)
            sat_val = 32'sh7fffffff;
        else if (sum_full < -65'sd2147483648)
            sat_val = 32'sh80000000;
        else
            sat_val = sum_full[31:0];
    end

    assign in_ready = (state_reg == S_IDLE);
    // output register can take a new item this cycle
    assign out_free = !out_valid || out_ready;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC && ddone && lane_reg)
            queue_mem[qcnt_reg[QAW-1:0]] <= nch_reg[0] ? {sat_val, a_reg} : {a_reg, sat_val};
        rd_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 10'd50;
            limit_reg <= 6'd30;
            ncnt_reg  <= '0;
            fresh_reg <= 1'b0;
            head_reg  <= '0;
            qcnt_reg  <= '0;
            out_valid <= 1'b0;
            got_pair  <= 1'b0;
            dreq      <= '0;
        end
        else
        begin
            dreq.start <= (state_reg == S_SETUP) || (state_reg == S_DIV);
            if (cfg_we)
            begin
                if (cfg_index == CFG_STEP)
                    step_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[5:0];
            end
            if (state_reg == S_OUT && out_free)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        unique case (op_t'(op))
                            OP_ADD:
                            begin
                                if (!(ncnt_reg != 3'd0 && nch_reg[ncnt_reg[1:0] - 2'd1] == channel))
                                begin
                                    if (ncnt_reg == 3'(TimelineLen))
                                    begin
                                        for (int j = 0; j < TimelineLen - 1; j++)
                                        begin
                                            nch_reg[j]  <= nch_reg[j+1];
                                            nval_reg[j] <= nval_reg[j+1];
                                            ntim_reg[j] <= ntim_reg[j+1];
                                        end
                                        nch_reg[TimelineLen-1]  <= channel;
                                        nval_reg[TimelineLen-1] <= sample_value;
                                        ntim_reg[TimelineLen-1] <= timestamp_ms;
                                    end
                                    else
                                    begin
                                        nch_reg[ncnt_reg[1:0]]  <= channel;
                                        nval_reg[ncnt_reg[1:0]] <= sample_value;
                                        ntim_reg[ncnt_reg[1:0]] <= timestamp_ms;
                                        ncnt_reg <= ncnt_reg + 3'd1;
                                    end
                                    fresh_reg <= 1'b1;
                                end
                            end
                            OP_CLEAR: ncnt_reg <= '0;
                            OP_READ:  state_reg <= S_CHECK;
                            default: ;
                        endcase
                    end
                end
                S_CHECK:
                begin
                    if (qcnt_reg == '0 && fresh_reg && ncnt_reg == 3'(TimelineLen))
                    begin
                        fresh_reg <= 1'b0;
                        if (nch_reg[0] == nch_reg[2] && nch_reg[1] == nch_reg[3]
                            && d1 > 0 && d2 > 0 && gspan > 0)
                        begin
                            kend_reg  <= '0;
                            state_reg <= S_SETUP;
                        end
                        else
                            state_reg <= S_POP;
                    end
                    else
                        state_reg <= S_POP;
                end
                S_SETUP:
                begin
                    // Find the least n with n*step >= span as (span+step-1)/step on the divider;
                    // stepping n up with one add and compare a cycle would be slow for big spans.
                    dreq.num_mag <= 64'(gspan) + 64'(step_eff) - 64'd1;
                    dreq.den     <= 28'(step_eff);
                    state_reg    <= S_NEXT;
                    lane_reg     <= 1'b0;
                    kidx_reg     <= '1;
                end
                S_NEXT:
                begin
                    if (kidx_reg == '1)
                    begin
                        if (ddone)
                        begin
                            kend_reg <= dquot[26:0];
                            kidx_reg <= (dquot[26:0] > 27'(limit_eff))
                                      ? dquot[26:0] - 27'(limit_eff) : 27'd0;
                            state_reg <= S_POINT;
                        end
                    end
                    else if (kidx_reg >= n_pts)
                    begin
                        head_reg  <= '0;
                        state_reg <= S_POP;
                    end
                    else
                        state_reg <= S_POINT;
                end
                S_POINT:
                begin
                    if (kidx_reg >= n_pts)
                    begin
                        head_reg  <= '0;
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        diff_reg <= lane_reg
                            ? 33'(nval_reg[3]) - 33'(nval_reg[1])
                            : 33'(nval_reg[2]) - 33'(nval_reg[0]);
                        off_reg <= lane_reg
                            ? $signed({2'b0, i_pt}) - $signed({2'b0, ntim_reg[1]})
                            : $signed({2'b0, i_pt}) - $signed({2'b0, ntim_reg[0]});
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 62'(diff_reg) * 62'(off_reg);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    neg_reg      <= prod_reg[61];
                    dreq.num_mag <= prod_reg[61] ? 64'(-prod_reg) : 64'(prod_reg);
                    dreq.den     <= lane_reg ? 28'(d2) : 28'(d1);
                    state_reg    <= S_ACC;
                end
                S_ACC:
                begin
                    if (ddone)
                    begin
                        if (!lane_reg)
                        begin
                            a_reg    <= sat_val;
                            lane_reg <= 1'b1;
                        end
                        else
                        begin
                            qcnt_reg <= qcnt_reg + QCW'(1);
                            lane_reg <= 1'b0;
                            kidx_reg <= kidx_reg + 27'd1;
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_POP:      state_reg <= S_MEMRD;
                S_MEMRD:    state_reg <= S_OUT;
                S_OUT:
                begin
                    // wait here while the previous item is still unread
                    if (out_free)
                    begin
                        if (qcnt_reg == '0)
                        begin
                            got_pair     <= 1'b0;
                            value_first  <= '0;
                            value_second <= '0;
                        end
                        else
                        begin
                            got_pair     <= 1'b1;
                            value_first  <= rd_reg[63:32];
                            value_second <= rd_reg[31:0];
                            head_reg     <= head_reg + QAW'(1);
                            qcnt_reg     <= qcnt_reg - QCW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
